// File: src/vrt_pkg.sv
// Shared constants, types and helper functions of the voxel ray traversal unit.
package vrt_pkg;

    localparam int MAP_SIDE  = 32;
    localparam int TYPE_BITS = 8;
    localparam int COORD_W   = $clog2(MAP_SIDE);
    localparam int MAP_DEPTH = MAP_SIDE * MAP_SIDE * MAP_SIDE;
    localparam int ADDR_W    = $clog2(MAP_DEPTH);

    localparam int CELL_W  = 14;
    localparam int FRAC_W  = 12;
    localparam int D0_W    = 13;
    localparam int MAG_W   = 16;
    localparam int LEN_W   = 32;
    localparam int LIM_W   = 20;
    localparam int LIM1_W  = 21;
    localparam int DM_W    = 37;
    localparam int T_W     = 53;
    localparam int S_W     = 74;
    localparam int P_W     = 70;
    localparam int Q_W     = 71;
    localparam int TMP_W   = 36;

    localparam int MUL_A_W    = 48;
    localparam int MUL_B_W    = 48;
    localparam int MUL_DIG_W  = 16;
    localparam int MUL_DIGITS = MUL_B_W / MUL_DIG_W;
    localparam int MUL_CNT_W  = $clog2(MUL_DIGITS);
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

    localparam int NUM_OPS = 27;
    localparam int OP_W    = 5;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_WALK_FIRST,
        ST_WALK_RD,
        ST_WALK_EV,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        OPD_M,
        OPD_D0,
        OPD_L,
        OPD_T,
        OPD_LIM,
        OPD_LIM1,
        OPD_TMP
    } opnd_t;

    typedef enum logic [2:0] {
        DST_L,
        DST_D,
        DST_T,
        DST_S,
        DST_TMP,
        DST_P,
        DST_Q
    } dst_t;

    typedef struct packed {
        opnd_t      a_sel;
        logic [1:0] a_ax;
        opnd_t      b_sel;
        logic [1:0] b_ax;
        dst_t       dst;
        logic [1:0] d_ax;
        logic [1:0] d_bx;
    } calc_op_t;

    function automatic calc_op_t mk_op(input opnd_t as, input logic [1:0] aa,
                                       input opnd_t bs, input logic [1:0] ba,
                                       input dst_t ds, input logic [1:0] da,
                                       input logic [1:0] db);
        calc_op_t o;
        o.a_sel = as;
        o.a_ax  = aa;
        o.b_sel = bs;
        o.b_ax  = ba;
        o.dst   = ds;
        o.d_ax  = da;
        o.d_bx  = db;
        return o;
    endfunction

    // Setup program: squared lengths, cross terms, distance terms, range bounds.
    function automatic calc_op_t calc_op(input logic [OP_W-1:0] idx);
        calc_op_t o;
        unique case (idx)
            5'd0:  o = mk_op(OPD_M, 2'd0, OPD_M, 2'd0, DST_L, 2'd0, 2'd0);
            5'd1:  o = mk_op(OPD_M, 2'd1, OPD_M, 2'd1, DST_L, 2'd1, 2'd0);
            5'd2:  o = mk_op(OPD_M, 2'd2, OPD_M, 2'd2, DST_L, 2'd2, 2'd0);
            5'd3:  o = mk_op(OPD_D0, 2'd0, OPD_M, 2'd1, DST_D, 2'd0, 2'd1);
            5'd4:  o = mk_op(OPD_D0, 2'd0, OPD_M, 2'd2, DST_D, 2'd0, 2'd2);
            5'd5:  o = mk_op(OPD_D0, 2'd1, OPD_M, 2'd0, DST_D, 2'd1, 2'd0);
            5'd6:  o = mk_op(OPD_D0, 2'd1, OPD_M, 2'd2, DST_D, 2'd1, 2'd2);
            5'd7:  o = mk_op(OPD_D0, 2'd2, OPD_M, 2'd0, DST_D, 2'd2, 2'd0);
            5'd8:  o = mk_op(OPD_D0, 2'd2, OPD_M, 2'd1, DST_D, 2'd2, 2'd1);
            5'd9:  o = mk_op(OPD_D0, 2'd0, OPD_L, 2'd0, DST_T, 2'd0, 2'd0);
            5'd10: o = mk_op(OPD_D0, 2'd1, OPD_L, 2'd0, DST_T, 2'd1, 2'd0);
            5'd11: o = mk_op(OPD_D0, 2'd2, OPD_L, 2'd0, DST_T, 2'd2, 2'd0);
            5'd12: o = mk_op(OPD_T, 2'd0, OPD_D0, 2'd0, DST_S, 2'd0, 2'd0);
            5'd13: o = mk_op(OPD_T, 2'd1, OPD_D0, 2'd1, DST_S, 2'd1, 2'd0);
            5'd14: o = mk_op(OPD_T, 2'd2, OPD_D0, 2'd2, DST_S, 2'd2, 2'd0);
            5'd15: o = mk_op(OPD_LIM, 2'd0, OPD_M, 2'd0, DST_TMP, 2'd0, 2'd0);
            5'd16: o = mk_op(OPD_TMP, 2'd0, OPD_TMP, 2'd0, DST_P, 2'd0, 2'd0);
            5'd17: o = mk_op(OPD_LIM1, 2'd0, OPD_M, 2'd0, DST_TMP, 2'd0, 2'd0);
            5'd18: o = mk_op(OPD_TMP, 2'd0, OPD_TMP, 2'd0, DST_Q, 2'd0, 2'd0);
            5'd19: o = mk_op(OPD_LIM, 2'd0, OPD_M, 2'd1, DST_TMP, 2'd0, 2'd0);
            5'd20: o = mk_op(OPD_TMP, 2'd0, OPD_TMP, 2'd0, DST_P, 2'd1, 2'd0);
            5'd21: o = mk_op(OPD_LIM1, 2'd0, OPD_M, 2'd1, DST_TMP, 2'd0, 2'd0);
            5'd22: o = mk_op(OPD_TMP, 2'd0, OPD_TMP, 2'd0, DST_Q, 2'd1, 2'd0);
            5'd23: o = mk_op(OPD_LIM, 2'd0, OPD_M, 2'd2, DST_TMP, 2'd0, 2'd0);
            5'd24: o = mk_op(OPD_TMP, 2'd0, OPD_TMP, 2'd0, DST_P, 2'd2, 2'd0);
            5'd25: o = mk_op(OPD_LIM1, 2'd0, OPD_M, 2'd2, DST_TMP, 2'd0, 2'd0);
            5'd26: o = mk_op(OPD_TMP, 2'd0, OPD_TMP, 2'd0, DST_Q, 2'd2, 2'd0);
            default: o = mk_op(OPD_M, 2'd0, OPD_M, 2'd0, DST_TMP, 2'd0, 2'd0);
        endcase
        return o;
    endfunction

    function automatic logic in_map(input logic signed [CELL_W-1:0] x,
                                    input logic signed [CELL_W-1:0] y,
                                    input logic signed [CELL_W-1:0] z);
        return !x[CELL_W-1] && (x < CELL_W'(MAP_SIDE)) &&
               !y[CELL_W-1] && (y < CELL_W'(MAP_SIDE)) &&
               !z[CELL_W-1] && (z < CELL_W'(MAP_SIDE));
    endfunction

    function automatic logic [ADDR_W-1:0] map_addr(input logic signed [CELL_W-1:0] x,
                                                   input logic signed [CELL_W-1:0] y,
                                                   input logic signed [CELL_W-1:0] z);
        return ADDR_W'(z[COORD_W-1:0]) * ADDR_W'(MAP_SIDE * MAP_SIDE) +
               ADDR_W'(y[COORD_W-1:0]) * ADDR_W'(MAP_SIDE) +
               ADDR_W'(x[COORD_W-1:0]);
    endfunction

endpackage

// File: src/vrt_mul.sv
// Digit-serial multiplier: one 16-bit digit of the second operand per cycle.
module vrt_mul (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [vrt_pkg::MUL_A_W-1:0]     a,
    input  logic [vrt_pkg::MUL_B_W-1:0]     b,
    output logic                            done,
    output logic [vrt_pkg::MUL_P_W-1:0]     prod
);

    logic [vrt_pkg::MUL_A_W-1:0]                    a_reg;
    logic [vrt_pkg::MUL_B_W-1:0]                    b_reg;
    logic [vrt_pkg::MUL_P_W-1:0]                    acc_reg;
    logic [vrt_pkg::MUL_CNT_W-1:0]                  dig_reg;
    logic                                           busy_reg;
    logic                                           done_reg;
    logic [vrt_pkg::MUL_A_W+vrt_pkg::MUL_DIG_W-1:0] partial;
    logic [vrt_pkg::MUL_P_W-1:0]                    shifted;
    logic                                           last;

    assign partial = a_reg * b_reg[vrt_pkg::MUL_DIG_W-1:0];
    assign shifted = vrt_pkg::MUL_P_W'(partial) << (vrt_pkg::MUL_DIG_W * dig_reg);
    assign last    = (b_reg >> vrt_pkg::MUL_DIG_W) == '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            dig_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                dig_reg  <= '0;
            end
            else if (busy_reg)
            begin
                dig_reg <= dig_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_reg + shifted;
            b_reg   <= b_reg >> vrt_pkg::MUL_DIG_W;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// File: src/vrt_map.sv
// Voxel map memory with a clearing sweep after reset.
module vrt_map (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [vrt_pkg::ADDR_W-1:0]        wr_addr,
    input  logic [vrt_pkg::TYPE_BITS-1:0]     wr_data,
    input  logic                              rd_en,
    input  logic [vrt_pkg::ADDR_W-1:0]        rd_addr,
    output logic [vrt_pkg::TYPE_BITS-1:0]     rd_data,
    output logic                              busy
);

    logic [vrt_pkg::TYPE_BITS-1:0] mem [vrt_pkg::MAP_DEPTH];
    logic [vrt_pkg::ADDR_W-1:0]    clr_addr_reg;
    logic                          clr_busy_reg;
    logic [vrt_pkg::TYPE_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == vrt_pkg::ADDR_W'(vrt_pkg::MAP_DEPTH - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_busy_reg;

endmodule

// File: src/voxel_ray_traversal_unit.sv
// Voxel ray traversal unit: voxel map, setup sequencer and DDA cell walk.
// A write request lands in the map at the accept edge. A cast with a nonzero
// direction runs 27 setup products on the shared digit-serial multiplier,
// then one map read per visited cell, then posts its result.
// One request at a time; a posted result may wait while the next
// request is taken. Reset clears the map by a sweep over all MAP_SIDE^3
// (32768) cells, during which no request is taken.
module voxel_ray_traversal_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic                cmd,
    input  logic signed [11:0]  cell_x,
    input  logic signed [11:0]  cell_y,
    input  logic signed [11:0]  cell_z,
    input  logic [7:0]          new_type,
    input  logic signed [23:0]  origin_x,
    input  logic signed [23:0]  origin_y,
    input  logic signed [23:0]  origin_z,
    input  logic signed [15:0]  dir_x,
    input  logic signed [15:0]  dir_y,
    input  logic signed [15:0]  dir_z,
    input  logic [19:0]         max_distance,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic                hit,
    output logic signed [11:0]  hit_x,
    output logic signed [11:0]  hit_y,
    output logic signed [11:0]  hit_z,
    output logic signed [1:0]   normal_x,
    output logic signed [1:0]   normal_y,
    output logic signed [1:0]   normal_z,
    output logic signed [12:0]  place_x,
    output logic signed [12:0]  place_y,
    output logic signed [12:0]  place_z,
    output logic [7:0]          hit_type
);

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    vrt_pkg::state_t              state_reg;
    vrt_pkg::state_t              state_next;
    logic [vrt_pkg::OP_W-1:0]     op_reg;
    logic                         out_valid_reg;

    logic                         req_accept;
    logic                         slot_free;
    logic                         mul_start;
    logic                         rd_en;
    logic                         dir_zero;
    logic                         op_last;
    vrt_pkg::calc_op_t            cur_op;

    // ------------------------------------------------------------------
    // Ray working set. Per axis a: d is the distance to the next boundary
    // along that axis, m is |dir|, L is |dir|^2.
    //   dm[a][b] = d_a * m_b  (cross terms for the axis race)
    //   t[a]     = d_a * L,   s[a] = d_a^2 * L
    //   p[a]     = lim^2 * m_a^2, q[a] = (lim+1)^2 * m_a^2
    // Stepping adds one cell to d_k, so all terms update by additions.
    // ------------------------------------------------------------------
    logic signed [vrt_pkg::CELL_W-1:0] cell_reg [3];
    logic signed [1:0]                 norm_reg [3];
    logic [vrt_pkg::D0_W-1:0]          d0_reg   [3];
    logic [vrt_pkg::MAG_W-1:0]         mag_reg  [3];
    logic [2:0]                        pos_reg;
    logic [2:0]                        nz_reg;
    logic [vrt_pkg::LEN_W-1:0]         len_reg;
    logic [vrt_pkg::LIM_W-1:0]         lim_reg;
    logic [vrt_pkg::DM_W-1:0]          dm_reg   [3][3];
    logic [vrt_pkg::T_W-1:0]           t_reg    [3];
    logic [vrt_pkg::S_W-1:0]           s_reg    [3];
    logic [vrt_pkg::P_W-1:0]           p_reg    [3];
    logic [vrt_pkg::Q_W-1:0]           q_reg    [3];
    logic [vrt_pkg::TMP_W-1:0]         tmp_reg;
    logic                              hit_reg;
    logic [vrt_pkg::TYPE_BITS-1:0]     type_reg;
    logic                              inmap_reg;

    // Result register
    logic                              out_hit_reg;
    logic signed [11:0]                out_cell_reg  [3];
    logic signed [1:0]                 out_norm_reg  [3];
    logic signed [12:0]                out_place_reg [3];
    logic [7:0]                        out_type_reg;

    // Request fields as per-axis arrays
    logic signed [23:0]                org [3];
    logic signed [15:0]                dir [3];

    // Multiplier and map
    logic [vrt_pkg::MUL_A_W-1:0]       mul_a;
    logic [vrt_pkg::MUL_B_W-1:0]       mul_b;
    logic                              mul_done;
    logic [vrt_pkg::MUL_P_W-1:0]       mul_prod;
    logic                              map_busy;
    logic                              wr_en;
    logic [vrt_pkg::ADDR_W-1:0]        wr_addr;
    logic [vrt_pkg::ADDR_W-1:0]        rd_addr;
    logic [vrt_pkg::TYPE_BITS-1:0]     rd_data;
    logic signed [vrt_pkg::CELL_W-1:0] wcx;
    logic signed [vrt_pkg::CELL_W-1:0] wcy;
    logic signed [vrt_pkg::CELL_W-1:0] wcz;

    // Walk decision
    logic [vrt_pkg::TYPE_BITS-1:0]     cell_type;
    logic                              cell_solid;
    logic                              near01;
    logic                              near02;
    logic                              near12;
    logic [1:0]                        k_ax;
    logic                              beyond_lim;
    logic                              walk_done;

    assign org[0] = origin_x;
    assign org[1] = origin_y;
    assign org[2] = origin_z;
    assign dir[0] = dir_x;
    assign dir[1] = dir_y;
    assign dir[2] = dir_z;

    assign req_accept = req_valid && !req_stall;
    assign slot_free  = !out_valid_reg || !rsp_stall;
    assign dir_zero   = (dir_x == '0) && (dir_y == '0) && (dir_z == '0);
    assign op_last    = op_reg == vrt_pkg::OP_W'(vrt_pkg::NUM_OPS - 1);
    assign cur_op     = vrt_pkg::calc_op(op_reg);

    // ------------------------------------------------------------------
    // Voxel map: writes land at the accept edge, only while idle, so a
    // walk read never overlaps a write to the same cell.
    // ------------------------------------------------------------------
    assign wcx     = vrt_pkg::CELL_W'(cell_x);
    assign wcy     = vrt_pkg::CELL_W'(cell_y);
    assign wcz     = vrt_pkg::CELL_W'(cell_z);
    assign wr_en   = req_accept && (cmd == vrt_pkg::CMD_WRITE) && vrt_pkg::in_map(wcx, wcy, wcz);
    assign wr_addr = vrt_pkg::map_addr(wcx, wcy, wcz);
    assign rd_addr = vrt_pkg::map_addr(cell_reg[0], cell_reg[1], cell_reg[2]);

    vrt_map u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (vrt_pkg::TYPE_BITS'(new_type)),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .busy    (map_busy)
    );

    // ------------------------------------------------------------------
    // Setup program operand selection
    // ------------------------------------------------------------------
    always_comb
    begin
        unique case (cur_op.a_sel)
            vrt_pkg::OPD_M:    mul_a = vrt_pkg::MUL_A_W'(mag_reg[cur_op.a_ax]);
            vrt_pkg::OPD_D0:   mul_a = vrt_pkg::MUL_A_W'(d0_reg[cur_op.a_ax]);
            vrt_pkg::OPD_L:    mul_a = vrt_pkg::MUL_A_W'(len_reg);
            vrt_pkg::OPD_T:    mul_a = vrt_pkg::MUL_A_W'(t_reg[cur_op.a_ax]);
            vrt_pkg::OPD_LIM:  mul_a = vrt_pkg::MUL_A_W'(lim_reg);
            vrt_pkg::OPD_LIM1: mul_a = vrt_pkg::MUL_A_W'(lim_reg) + 1'b1;
            vrt_pkg::OPD_TMP:  mul_a = vrt_pkg::MUL_A_W'(tmp_reg);
            default:           mul_a = '0;
        endcase
    end

    always_comb
    begin
        unique case (cur_op.b_sel)
            vrt_pkg::OPD_M:    mul_b = vrt_pkg::MUL_B_W'(mag_reg[cur_op.b_ax]);
            vrt_pkg::OPD_D0:   mul_b = vrt_pkg::MUL_B_W'(d0_reg[cur_op.b_ax]);
            vrt_pkg::OPD_L:    mul_b = vrt_pkg::MUL_B_W'(len_reg);
            vrt_pkg::OPD_T:    mul_b = vrt_pkg::MUL_B_W'(t_reg[cur_op.b_ax]);
            vrt_pkg::OPD_LIM:  mul_b = vrt_pkg::MUL_B_W'(lim_reg);
            vrt_pkg::OPD_LIM1: mul_b = vrt_pkg::MUL_B_W'(lim_reg) + 1'b1;
            vrt_pkg::OPD_TMP:  mul_b = vrt_pkg::MUL_B_W'(tmp_reg);
            default:           mul_b = '0;
        endcase
    end

    vrt_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    // ------------------------------------------------------------------
    // Walk decision. The axis race: X wins only when strictly nearer than
    // both others, then Y when strictly nearer than Z, otherwise Z. An axis
    // that does not move never wins against a moving one.
    // ------------------------------------------------------------------
    assign cell_type  = inmap_reg ? rd_data : '0;
    assign cell_solid = cell_type != '0;

    assign near01 = nz_reg[0] && (!nz_reg[1] || (dm_reg[0][1] < dm_reg[1][0]));
    assign near02 = nz_reg[0] && (!nz_reg[2] || (dm_reg[0][2] < dm_reg[2][0]));
    assign near12 = nz_reg[1] && (!nz_reg[2] || (dm_reg[1][2] < dm_reg[2][1]));

    always_comb
    begin
        if (near01)
        begin
            k_ax = near02 ? 2'd0 : 2'd2;
        end
        else
        begin
            k_ax = near12 ? 2'd1 : 2'd2;
        end
    end

    // Chosen boundary past the range: d^2 * L > lim^2 * m^2
    assign beyond_lim = s_reg[k_ax] > vrt_pkg::S_W'(p_reg[k_ax]);

    // After a step: end when every moving axis is past range plus epsilon
    always_comb
    begin
        walk_done = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            if (nz_reg[a] && !(s_reg[a] > vrt_pkg::S_W'(q_reg[a])))
            begin
                walk_done = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // State machine
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vrt_pkg::ST_IDLE;
            op_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (req_accept)
            begin
                op_reg <= '0;
            end
            else if (state_reg == vrt_pkg::ST_MUL_WAIT && mul_done)
            begin
                op_reg <= op_reg + 1'b1;
            end
            if (state_reg == vrt_pkg::ST_FINISH && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vrt_pkg::ST_IDLE:
            begin
                if (req_valid && !map_busy && cmd == vrt_pkg::CMD_CAST)
                begin
                    state_next = dir_zero ? vrt_pkg::ST_FINISH : vrt_pkg::ST_MUL_GO;
                end
            end
            vrt_pkg::ST_MUL_GO:
            begin
                state_next = vrt_pkg::ST_MUL_WAIT;
            end
            vrt_pkg::ST_MUL_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = op_last ? vrt_pkg::ST_WALK_FIRST : vrt_pkg::ST_MUL_GO;
                end
            end
            vrt_pkg::ST_WALK_FIRST:
            begin
                state_next = vrt_pkg::ST_WALK_EV;
            end
            vrt_pkg::ST_WALK_RD:
            begin
                state_next = walk_done ? vrt_pkg::ST_FINISH : vrt_pkg::ST_WALK_EV;
            end
            vrt_pkg::ST_WALK_EV:
            begin
                if (cell_solid || beyond_lim)
                begin
                    state_next = vrt_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = vrt_pkg::ST_WALK_RD;
                end
            end
            vrt_pkg::ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = vrt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vrt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_stall = (state_reg != vrt_pkg::ST_IDLE) || map_busy;
        mul_start = state_reg == vrt_pkg::ST_MUL_GO;
        rd_en     = (state_reg == vrt_pkg::ST_WALK_FIRST) || (state_reg == vrt_pkg::ST_WALK_RD);
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (req_accept && cmd == vrt_pkg::CMD_CAST)
        begin
            // Latch the ray: starting cell, first boundary distance, direction
            for (int a = 0; a < 3; a++)
            begin
                cell_reg[a] <= vrt_pkg::CELL_W'($signed(org[a][23:vrt_pkg::FRAC_W]));
                norm_reg[a] <= 2'sd0;
                mag_reg[a]  <= dir[a][15] ? vrt_pkg::MAG_W'(-dir[a])
                                          : vrt_pkg::MAG_W'(dir[a]);
                pos_reg[a]  <= !dir[a][15] && (dir[a] != '0);
                nz_reg[a]   <= dir[a] != '0;
                if (!dir[a][15] && (dir[a] != '0))
                begin
                    d0_reg[a] <= vrt_pkg::D0_W'(1 << vrt_pkg::FRAC_W)
                                 - vrt_pkg::D0_W'(org[a][vrt_pkg::FRAC_W-1:0]);
                end
                else
                begin
                    d0_reg[a] <= vrt_pkg::D0_W'(org[a][vrt_pkg::FRAC_W-1:0]);
                end
            end
            len_reg <= '0;
            lim_reg <= max_distance;
            hit_reg <= 1'b0;
        end
        else if (state_reg == vrt_pkg::ST_MUL_WAIT && mul_done)
        begin
            unique case (cur_op.dst)
                vrt_pkg::DST_L:   len_reg <= len_reg + vrt_pkg::LEN_W'(mul_prod);
                vrt_pkg::DST_D:   dm_reg[cur_op.d_ax][cur_op.d_bx] <= vrt_pkg::DM_W'(mul_prod);
                vrt_pkg::DST_T:   t_reg[cur_op.d_ax] <= vrt_pkg::T_W'(mul_prod);
                vrt_pkg::DST_S:   s_reg[cur_op.d_ax] <= vrt_pkg::S_W'(mul_prod);
                vrt_pkg::DST_TMP: tmp_reg <= vrt_pkg::TMP_W'(mul_prod);
                vrt_pkg::DST_P:   p_reg[cur_op.d_ax] <= vrt_pkg::P_W'(mul_prod);
                vrt_pkg::DST_Q:   q_reg[cur_op.d_ax] <= vrt_pkg::Q_W'(mul_prod);
                default:          tmp_reg <= tmp_reg;
            endcase
        end
        else if (state_reg == vrt_pkg::ST_WALK_EV)
        begin
            if (cell_solid)
            begin
                hit_reg  <= 1'b1;
                type_reg <= cell_type;
            end
            else if (!beyond_lim)
            begin
                // Advance one cell along the winning axis
                for (int a = 0; a < 3; a++)
                begin
                    if (a == int'(k_ax))
                    begin
                        cell_reg[a] <= pos_reg[a] ? cell_reg[a] + vrt_pkg::CELL_W'(1)
                                                  : cell_reg[a] - vrt_pkg::CELL_W'(1);
                        norm_reg[a] <= pos_reg[a] ? -2'sd1 : 2'sd1;
                        t_reg[a]    <= t_reg[a]
                                       + (vrt_pkg::T_W'(len_reg) << vrt_pkg::FRAC_W);
                        s_reg[a]    <= s_reg[a]
                                       + (vrt_pkg::S_W'(t_reg[a]) << (vrt_pkg::FRAC_W + 1))
                                       + (vrt_pkg::S_W'(len_reg) << (2 * vrt_pkg::FRAC_W));
                        for (int b = 0; b < 3; b++)
                        begin
                            if (b != a)
                            begin
                                dm_reg[a][b] <= dm_reg[a][b]
                                    + (vrt_pkg::DM_W'(mag_reg[b]) << vrt_pkg::FRAC_W);
                            end
                        end
                    end
                    else
                    begin
                        norm_reg[a] <= 2'sd0;
                    end
                end
            end
        end
        if (rd_en)
        begin
            inmap_reg <= vrt_pkg::in_map(cell_reg[0], cell_reg[1], cell_reg[2]);
        end
    end

    // Post the result; a miss carries zeros in every field
    always_ff @(posedge clk)
    begin
        if (state_reg == vrt_pkg::ST_FINISH && slot_free)
        begin
            out_hit_reg  <= hit_reg;
            out_type_reg <= hit_reg ? 8'(type_reg) : 8'd0;
            for (int a = 0; a < 3; a++)
            begin
                out_cell_reg[a]  <= hit_reg ? 12'(cell_reg[a]) : 12'sd0;
                out_norm_reg[a]  <= hit_reg ? norm_reg[a] : 2'sd0;
                out_place_reg[a] <= hit_reg ? 13'(cell_reg[a] + vrt_pkg::CELL_W'(norm_reg[a]))
                                            : 13'sd0;
            end
        end
    end

    assign rsp_valid = out_valid_reg;
    assign hit       = out_hit_reg;
    assign hit_x     = out_cell_reg[0];
    assign hit_y     = out_cell_reg[1];
    assign hit_z     = out_cell_reg[2];
    assign normal_x  = out_norm_reg[0];
    assign normal_y  = out_norm_reg[1];
    assign normal_z  = out_norm_reg[2];
    assign place_x   = out_place_reg[0];
    assign place_y   = out_place_reg[1];
    assign place_z   = out_place_reg[2];
    assign hit_type  = out_type_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_rsp_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == vrt_pkg::ST_FINISH))
        else $error("result posted outside finish state");

    a_mul_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> state_reg == vrt_pkg::ST_MUL_WAIT)
        else $error("multiplier finished while sequencer not waiting");

    a_eval_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == vrt_pkg::ST_WALK_EV |->
            $past(state_reg == vrt_pkg::ST_WALK_FIRST || state_reg == vrt_pkg::ST_WALK_RD))
        else $error("cell evaluated without a preceding map read");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !hit |-> hit_type == 8'd0 && place_x == 13'sd0 && normal_y == 2'sd0)
        else $error("miss result carries nonzero fields");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the voxel ray traversal unit: map writes and DDA ray casts.
`timescale 1ns / 100ps

module tb_top;

    localparam int CLK_HALF     = 6;
    localparam int RST_CYCLES   = 7;
    localparam int RAND_ITEMS   = 1600;
    localparam int DRAIN_CYCLES = 300;
    localparam int MAX_REPORTS  = 10;

    // One request as presented on the request port.
    typedef struct {
        logic               cmd;
        logic signed [11:0] cx, cy, cz;
        logic [7:0]         ntype;
        logic signed [23:0] ox, oy, oz;
        logic signed [15:0] dx, dy, dz;
        logic [19:0]        maxd;
    } ray_req_t;

    // One cast outcome as seen on the response port.
    typedef struct packed {
        logic               hit;
        logic signed [11:0] hx, hy, hz;
        logic signed [1:0]  nx, ny, nz;
        logic signed [12:0] px, py, pz;
        logic [7:0]         htype;
    } cast_rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               req_valid = 1'b0;
    logic               req_stall;
    logic               cmd = vrt_pkg::CMD_WRITE;
    logic signed [11:0] cell_x = '0, cell_y = '0, cell_z = '0;
    logic [7:0]         new_type = '0;
    logic signed [23:0] origin_x = '0, origin_y = '0, origin_z = '0;
    logic signed [15:0] dir_x = '0, dir_y = '0, dir_z = '0;
    logic [19:0]        max_distance = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    logic               hit;
    logic signed [11:0] hit_x, hit_y, hit_z;
    logic signed [1:0]  normal_x, normal_y, normal_z;
    logic signed [12:0] place_x, place_y, place_z;
    logic [7:0]         hit_type;

    voxel_ray_traversal_unit dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall),
        .cmd(cmd), .cell_x(cell_x), .cell_y(cell_y), .cell_z(cell_z),
        .new_type(new_type),
        .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
        .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
        .max_distance(max_distance),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
        .hit(hit), .hit_x(hit_x), .hit_y(hit_y), .hit_z(hit_z),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .place_x(place_x), .place_y(place_y), .place_z(place_z),
        .hit_type(hit_type)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the voxel map and the per-cast walk state
    // ------------------------------------------------------------------
    logic [7:0]      shadow_map [vrt_pkg::MAP_SIDE*vrt_pkg::MAP_SIDE*vrt_pkg::MAP_SIDE];
    int              walk_step [3];
    longint unsigned walk_mag [3];
    longint unsigned walk_dist [3];
    longint unsigned walk_len2;

    ray_req_t  pending_reqs [$];
    cast_rsp_t expected_casts [$];
    int        mismatches = 0;

    function automatic bit cell_in_map(input longint x, input longint y, input longint z);
        return x >= 0 && x < vrt_pkg::MAP_SIDE && y >= 0 && y < vrt_pkg::MAP_SIDE &&
               z >= 0 && z < vrt_pkg::MAP_SIDE;
    endfunction

    function automatic int cell_slot(input longint x, input longint y, input longint z);
        return int'((z * vrt_pkg::MAP_SIDE + y) * vrt_pkg::MAP_SIDE + x);
    endfunction

    // Next boundary of axis a strictly closer than that of axis b.
    function automatic bit boundary_closer(input int a, input int b);
        if (walk_step[a] == 0)
            return 1'b0;
        if (walk_step[b] == 0)
            return 1'b1;
        return walk_dist[a] * walk_mag[b] < walk_dist[b] * walk_mag[a];
    endfunction

    // Next boundary of axis a lies past range lim (Q8.12), compared squared and exact.
    function automatic bit boundary_past(input int a, input longint unsigned lim);
        logic [127:0] lhs, rhs;
        lhs = 128'(walk_dist[a]) * 128'(walk_dist[a]) * 128'(walk_len2);
        rhs = 128'(lim) * 128'(lim) * 128'(walk_mag[a]) * 128'(walk_mag[a]);
        return lhs > rhs;
    endfunction

    // Walk the ray cell by cell and return the first solid cell or a miss.
    function automatic cast_rsp_t trace_ray(input ray_req_t r);
        cast_rsp_t          res;
        longint             cur [3];
        int                 nrm [3];
        logic signed [23:0] org [3];
        logic signed [15:0] drv [3];
        longint unsigned    lim;
        logic [7:0]         kind;
        int                 k;
        bit                 all_past;
        res = '{default: '0};
        org = '{r.ox, r.oy, r.oz};
        drv = '{r.dx, r.dy, r.dz};
        nrm = '{0, 0, 0};
        walk_len2 = 0;
        for (int a = 0; a < 3; a++)
        begin
            longint d;
            d = longint'(drv[a]);
            cur[a] = longint'(org[a]) >>> 12;
            walk_step[a] = d > 0 ? 1 : (d < 0 ? -1 : 0);
            walk_mag[a] = longint'(d < 0 ? -d : d);
            walk_len2 += walk_mag[a] * walk_mag[a];
            walk_dist[a] = walk_step[a] > 0 ? 4096 - longint'(org[a][11:0])
                                            : longint'(org[a][11:0]);
        end
        if (walk_len2 == 0)
            return res;
        lim = longint'(r.maxd);
        forever
        begin
            kind = '0;
            if (cell_in_map(cur[0], cur[1], cur[2]))
                kind = shadow_map[cell_slot(cur[0], cur[1], cur[2])];
            if (kind != 0)
            begin
                res.hit = 1'b1;
                res.hx = 12'(cur[0]); res.hy = 12'(cur[1]); res.hz = 12'(cur[2]);
                res.nx = 2'(nrm[0]);  res.ny = 2'(nrm[1]);  res.nz = 2'(nrm[2]);
                res.px = 13'(cur[0] + nrm[0]);
                res.py = 13'(cur[1] + nrm[1]);
                res.pz = 13'(cur[2] + nrm[2]);
                res.htype = kind;
                return res;
            end
            // X needs a strict win over both; a tie falls to Y, then Z
            if (boundary_closer(0, 1))
                k = boundary_closer(0, 2) ? 0 : 2;
            else
                k = boundary_closer(1, 2) ? 1 : 2;
            if (boundary_past(k, lim))
                return res;
            cur[k] += walk_step[k];
            nrm = '{0, 0, 0};
            nrm[k] = -walk_step[k];
            walk_dist[k] += 4096;
            all_past = 1'b1;
            for (int a = 0; a < 3; a++)
                if (walk_step[a] != 0 && !boundary_past(a, lim + 1))
                    all_past = 1'b0;
            if (all_past)
                return res;
        end
    endfunction

    // Apply one accepted request to the shadow map or queue its cast outcome.
    function automatic void absorb_request(input ray_req_t r);
        if (r.cmd == vrt_pkg::CMD_WRITE)
        begin
            if (cell_in_map(r.cx, r.cy, r.cz))
                shadow_map[cell_slot(r.cx, r.cy, r.cz)] = r.ntype;
        end
        else
            expected_casts.push_back(trace_ray(r));
    endfunction

    // ------------------------------------------------------------------
    // Request builders
    // ------------------------------------------------------------------
    function automatic ray_req_t noise_req();
        ray_req_t r;
        r.cmd = vrt_pkg::CMD_WRITE;
        r.cx = 12'($urandom); r.cy = 12'($urandom); r.cz = 12'($urandom);
        r.ntype = 8'($urandom);
        r.ox = 24'($urandom); r.oy = 24'($urandom); r.oz = 24'($urandom);
        r.dx = 16'($urandom); r.dy = 16'($urandom); r.dz = 16'($urandom);
        r.maxd = 20'($urandom);
        return r;
    endfunction

    function automatic ray_req_t write_req(input int x, input int y, input int z,
                                           input int kind);
        ray_req_t r;
        r = noise_req();
        r.cmd = vrt_pkg::CMD_WRITE;
        r.cx = 12'(x); r.cy = 12'(y); r.cz = 12'(z);
        r.ntype = 8'(kind);
        return r;
    endfunction

    // Origins are given in cells plus a 12-bit fraction.
    function automatic ray_req_t cast_req(input int ox, input int oy, input int oz,
                                          input int dx, input int dy, input int dz,
                                          input int md);
        ray_req_t r;
        r = noise_req();
        r.cmd = vrt_pkg::CMD_CAST;
        r.ox = 24'(ox); r.oy = 24'(oy); r.oz = 24'(oz);
        r.dx = 16'(dx); r.dy = 16'(dy); r.dz = 16'(dz);
        r.maxd = 20'(md);
        return r;
    endfunction

    function automatic int rand_origin();
        int c, f;
        c = $urandom_range(0, 40) - 4;
        f = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 4095);
        return c * 4096 + f;
    endfunction

    function automatic int rand_dir();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return $urandom_range(0, 1) ? 32767 : -32768;
            2: return $urandom_range(0, 64) - 32;
            default: return int'(16'($urandom)) - (($urandom_range(0, 1)) ? 0 : 0);
        endcase
    endfunction

    function automatic ray_req_t rand_cast();
        ray_req_t r;
        int dx, dy, dz;
        if ($urandom_range(0, 19) == 0)
        begin
            r = noise_req();
            r.cmd = vrt_pkg::CMD_CAST;
            return r;
        end
        dx = $signed(16'(rand_dir()));
        dy = $signed(16'(rand_dir()));
        dz = $signed(16'(rand_dir()));
        return cast_req(rand_origin(), rand_origin(), rand_origin(), dx, dy, dz,
                        $urandom_range(0, 9) == 0 ? $urandom_range(0, 20'hFFFFF)
                                                  : $urandom_range(0, 48 * 4096));
    endfunction

    function automatic ray_req_t rand_write();
        if ($urandom_range(0, 9) == 0)
            return noise_req();
        if ($urandom_range(0, 1))
            return write_req($urandom_range(8, 23), $urandom_range(8, 23),
                             $urandom_range(8, 23),
                             $urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 255));
        return write_req($urandom_range(0, vrt_pkg::MAP_SIDE - 1),
                         $urandom_range(0, vrt_pkg::MAP_SIDE - 1),
                         $urandom_range(0, vrt_pkg::MAP_SIDE - 1), $urandom_range(0, 255));
    endfunction

    // ------------------------------------------------------------------
    // Request driver: bursts of random length with random gaps between them
    // ------------------------------------------------------------------
    ray_req_t live_req;
    bit       slot_free;
    int       burst_left = 0;
    int       gap_left = 0;

    task automatic present(input ray_req_t r);
        cmd <= r.cmd;
        cell_x <= r.cx; cell_y <= r.cy; cell_z <= r.cz;
        new_type <= r.ntype;
        origin_x <= r.ox; origin_y <= r.oy; origin_z <= r.oz;
        dir_x <= r.dx; dir_y <= r.dy; dir_z <= r.dz;
        max_distance <= r.maxd;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            slot_free = !req_valid;
            // Retire the request the block just took
            if (req_valid && !req_stall)
            begin
                absorb_request(live_req);
                slot_free = 1'b1;
            end
            // Hold a stalled request; otherwise idle or present the next one
            if (slot_free)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    live_req = pending_reqs.pop_front();
                    present(live_req);
                    req_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Response side: stall pattern in phases (none, light, heavy)
    // ------------------------------------------------------------------
    int stall_phase = 0;
    int phase_left = 0;

    always @(posedge clk)
    begin
        if (phase_left == 0)
        begin
            stall_phase = $urandom_range(0, 2);
            phase_left = $urandom_range(20, 300);
        end
        else
            phase_left--;
        case (stall_phase)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 9) < 3);
            default: rsp_stall <= ($urandom_range(0, 9) < 8);
        endcase
    end

    // ------------------------------------------------------------------
    // Response monitor: compare each taken result with the oldest prediction
    // ------------------------------------------------------------------
    cast_rsp_t seen_cast, want_cast;

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            seen_cast = '{hit, hit_x, hit_y, hit_z, normal_x, normal_y, normal_z,
                          place_x, place_y, place_z, hit_type};
            if (expected_casts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected cast result hit=%0b cell=(%0d,%0d,%0d)",
                             $realtime, hit, hit_x, hit_y, hit_z);
            end
            else
            begin
                want_cast = expected_casts.pop_front();
                if (seen_cast != want_cast)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("%0t: cast result differs", $realtime);
                        $display("  exp hit=%0b cell=(%0d,%0d,%0d) n=(%0d,%0d,%0d) p=(%0d,%0d,%0d) t=%0d",
                                 want_cast.hit, want_cast.hx, want_cast.hy, want_cast.hz,
                                 want_cast.nx, want_cast.ny, want_cast.nz,
                                 want_cast.px, want_cast.py, want_cast.pz, want_cast.htype);
                        $display("  got hit=%0b cell=(%0d,%0d,%0d) n=(%0d,%0d,%0d) p=(%0d,%0d,%0d) t=%0d",
                                 seen_cast.hit, seen_cast.hx, seen_cast.hy, seen_cast.hz,
                                 seen_cast.nx, seen_cast.ny, seen_cast.nz,
                                 seen_cast.px, seen_cast.py, seen_cast.pz, seen_cast.htype);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        foreach (shadow_map[i])
            shadow_map[i] = '0;

        // Directed: map extremes, writes outside the map, types 0 and 255
        pending_reqs.push_back(write_req(0, 0, 0, 255));
        pending_reqs.push_back(write_req(31, 31, 31, 1));
        pending_reqs.push_back(write_req(-2048, 5, 5, 9));
        pending_reqs.push_back(write_req(2047, -1, 32, 9));
        pending_reqs.push_back(write_req(6, 5, 5, 11));
        pending_reqs.push_back(write_req(5, 6, 5, 12));
        pending_reqs.push_back(write_req(5, 5, 6, 13));
        pending_reqs.push_back(write_req(20, 20, 20, 77));
        // Zero direction gives a miss
        pending_reqs.push_back(cast_req(5*4096+2048, 5*4096+2048, 5*4096+2048, 0, 0, 0, 20'hFFFFF));
        // Three-way tie at the cube center resolves to Z
        pending_reqs.push_back(cast_req(5*4096+2048, 5*4096+2048, 5*4096+2048, 100, 100, 100,
                                        8*4096));
        // Origin inside a solid cell: zero normal, place equals hit
        pending_reqs.push_back(cast_req(20*4096+7, 20*4096+4095, 20*4096, -32768, 32767, 1,
                                        0));
        // Negative direction from an exact boundary steps at t=0
        pending_reqs.push_back(cast_req(21*4096, 20*4096+2048, 20*4096+2048, -16384, 0, 0,
                                        4096));
        // Range just short of and just reaching the block
        pending_reqs.push_back(cast_req(18*4096, 20*4096+2048, 20*4096+2048, 16384, 0, 0,
                                        2*4096 - 1));
        pending_reqs.push_back(cast_req(18*4096, 20*4096+2048, 20*4096+2048, 16384, 0, 0,
                                        2*4096));
        // Corner cells hit from outside the map
        pending_reqs.push_back(cast_req(-3*4096, -3*4096, -3*4096, 1, 1, 1, 20'hFFFFF));
        pending_reqs.push_back(cast_req(35*4096, 31*4096+2048, 31*4096+2048, -32768, 0, 0,
                                        20'hFFFFF));
        // Extreme origins and directions
        pending_reqs.push_back(cast_req(-8388608, 8388607, 0, 32767, -32768, -1, 20'hFFFFF));
        pending_reqs.push_back(cast_req(8388607, -8388608, -8388608, -1, 1, 32767, 0));
        // Clear a cell and pass through where it was
        pending_reqs.push_back(write_req(20, 20, 20, 0));
        pending_reqs.push_back(cast_req(18*4096, 20*4096+2048, 20*4096+2048, 16384, 0, 0,
                                        4*4096));

        // Random: seed the map, then a mix of writes and mostly in-range casts
        for (int n = 0; n < RAND_ITEMS; n++)
            if (n < 300 || $urandom_range(0, 9) < 3)
                pending_reqs.push_back(rand_write());
            else
                pending_reqs.push_back(rand_cast());

        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every request to be taken and every prediction to be met
        while (pending_reqs.size() > 0 || req_valid || expected_casts.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_casts.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog: reset sweep plus worst-case walks and stalls, with ample margin
    initial
    begin
        #400ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
